[rtl/owms_pkg.sv]
// owms_pkg: shared types, codes and helpers for the 1-wire rom search master
// no dependencies
package owms_pkg;

   localparam int unsigned TickWidth  = 10;
   localparam int unsigned SlotWidth  = 8;
   localparam int unsigned RomWidth   = 64;
   localparam int unsigned PosWidth   = 7;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 10;

   localparam logic [7:0] SearchCmd = 8'hF0;
   localparam logic [7:0] DefMaxDevices = 8'd8;

   // input modes
   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_RESET  = 3'd1;
   localparam logic [2:0] MODE_WRITE  = 3'd2;
   localparam logic [2:0] MODE_READ   = 3'd3;
   localparam logic [2:0] MODE_SEARCH = 3'd4;

   // result events
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_RESET    = 3'd1;
   localparam logic [2:0] EV_WRITE    = 3'd2;
   localparam logic [2:0] EV_READ     = 3'd3;
   localparam logic [2:0] EV_FOUND    = 3'd4;
   localparam logic [2:0] EV_END      = 3'd5;
   localparam logic [2:0] EV_REJECT   = 3'd6;

   // register indexes
   localparam logic [2:0] CSR_RESET_LOW  = 3'd0;
   localparam logic [2:0] CSR_PRES_WAIT  = 3'd1;
   localparam logic [2:0] CSR_RESET_TAIL = 3'd2;
   localparam logic [2:0] CSR_SHORT_LOW  = 3'd3;
   localparam logic [2:0] CSR_ZERO_LOW   = 3'd4;
   localparam logic [2:0] CSR_READ_SAMP  = 3'd5;
   localparam logic [2:0] CSR_SLOT       = 3'd6;
   localparam logic [2:0] CSR_MAX_DEV    = 3'd7;

   // phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_RLOW  = 3'd1;
   localparam logic [2:0] PH_RWAIT = 3'd2;
   localparam logic [2:0] PH_RTAIL = 3'd3;
   localparam logic [2:0] PH_SLOT  = 3'd4;

   localparam logic [1:0] JOB_RESET  = 2'd0;
   localparam logic [1:0] JOB_WRITE  = 2'd1;
   localparam logic [1:0] JOB_READ   = 2'd2;
   localparam logic [1:0] JOB_SEARCH = 2'd3;

   localparam logic [2:0] ST_RESET = 3'd0;
   localparam logic [2:0] ST_CMD   = 3'd1;
   localparam logic [2:0] ST_ID    = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_DIR   = 3'd4;

   localparam logic [1:0] SK_W0 = 2'd0;
   localparam logic [1:0] SK_W1 = 2'd1;
   localparam logic [1:0] SK_RD = 2'd2;

   typedef struct packed {
      logic [9:0] reset_low;
      logic [9:0] presence_wait;
      logic [9:0] reset_tail;
      logic [7:0] short_low;
      logic [7:0] zero_low;
      logic [7:0] read_sample;
      logic [7:0] slot;
      logic [7:0] max_devices;
   } cfg_type;

   typedef struct packed {
      logic        line_low;
      logic        busy_res;
      logic [2:0]  event_res;
      logic        presence;
      logic [7:0]  data_byte;
      logic [63:0] rom_code;
      logic [7:0]  device_count;
      logic        last_device;
   } rsp_type;

   // zero counts act as one
   function automatic logic [9:0] at_least_one(input logic [9:0] v);
      at_least_one = (v == '0) ? 10'd1 : v;
   endfunction

endpackage

[rtl/owms_csr.sv]
// owms_csr: configuration register bank
// depends on owms_pkg
module owms_csr #(
   parameter logic [7:0] MaxDevicesDefault = owms_pkg::DefMaxDevices
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [owms_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [owms_pkg::CsrDataWidth-1:0] csr_data,
   output owms_pkg::cfg_type             cfg
);
   import owms_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RESET_LOW:  cfg_in.reset_low     = csr_data;
            CSR_PRES_WAIT:  cfg_in.presence_wait = csr_data;
            CSR_RESET_TAIL: cfg_in.reset_tail    = csr_data;
            CSR_SHORT_LOW:  cfg_in.short_low     = csr_data[7:0];
            CSR_ZERO_LOW:   cfg_in.zero_low      = csr_data[7:0];
            CSR_READ_SAMP:  cfg_in.read_sample   = csr_data[7:0];
            CSR_SLOT:       cfg_in.slot          = csr_data[7:0];
            CSR_MAX_DEV:    cfg_in.max_devices   = csr_data[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{reset_low: 10'd480, presence_wait: 10'd70, reset_tail: 10'd410,
                     short_low: 8'd6, zero_low: 8'd60, read_sample: 8'd9,
                     slot: 8'd70, max_devices: MaxDevicesDefault};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/owms_core.sv]
// owms_core: bus sequencer, one word per cycle while rsp is not stalled,
// result held in an output register; depends on owms_pkg
module owms_core (
   input  logic                clock,
   input  logic                reset,
   input  owms_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_mode,
   input  logic                req_line_level,
   input  logic [7:0]          req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output owms_pkg::rsp_type   rsp
);
   import owms_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [9:0]  tick_ff, tick_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [63:0] rom_ff, rom_in;
   logic [6:0]  idpos_ff, idpos_in;
   logic [6:0]  lastf_ff, lastf_in;
   logic [6:0]  forkm_ff, forkm_in;
   logic        first_ff, first_in;
   logic [7:0]  found_ff, found_in;
   logic        done_ff, done_in;
   logic        drive_ff, drive_in;
   logic [1:0]  job_ff, job_in;
   logic [2:0]  stage_ff, stage_in;
   logic [1:0]  kind_ff, kind_in;
   logic        samp_ff, samp_in;
   logic        pres_ff, pres_in;
   logic        vld_ff, vld_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic [9:0]  tnext;
   logic [7:0]  sl, lo, sp_sat;
   logic [8:0]  sp;
   logic        samp_now;
   logic [7:0]  shr;
   logic        cmp, dir;
   logic [5:0]  bitpos;
   logic [6:0]  idnext;
   logic [7:0]  fnext, maxd;

   assign req_ready = !vld_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   // slot timing
   always_comb begin
      sl = (cfg.slot < 8'd2) ? 8'd2 : cfg.slot;
      lo = (kind_ff == SK_W0) ? cfg.zero_low : cfg.short_low;
      if (lo == '0) lo = 8'd1;
      if (lo > sl - 8'd1) lo = sl - 8'd1;
      sp = {1'b0, lo} + {1'b0, ((cfg.read_sample == '0) ? 8'd1 : cfg.read_sample)};
      sp_sat = (sp > {1'b0, sl}) ? sl : sp[7:0];
   end

   // next state
   always_comb begin
      phase_in = phase_ff; tick_in = tick_ff; bit_in = bit_ff; shift_in = shift_ff;
      rom_in = rom_ff; idpos_in = idpos_ff; lastf_in = lastf_ff; forkm_in = forkm_ff;
      first_in = first_ff; found_in = found_ff; done_in = done_ff; drive_in = drive_ff;
      job_in = job_ff; stage_in = stage_ff; kind_in = kind_ff; samp_in = samp_ff;
      pres_in = pres_ff;
      rsp_in = '0;
      tnext = tick_ff + 10'd1;
      samp_now = samp_ff;
      shr = {1'b0, shift_ff[7:1]};
      cmp = 1'b0; dir = 1'b0;
      bitpos = idpos_ff[5:0] - 6'd1;
      idnext = idpos_ff + 7'd1;
      fnext = found_ff + 8'd1;
      maxd = (cfg.max_devices == '0) ? 8'd1 : cfg.max_devices;

      if (req_mode != MODE_TICK) begin
         if (phase_ff != PH_IDLE || req_mode > MODE_SEARCH) begin
            rsp_in.event_res = EV_REJECT;
         end else begin
            case (req_mode)
               MODE_RESET: begin
                  job_in = JOB_RESET;
                  phase_in = PH_RLOW; tick_in = '0; drive_in = 1'b1;
               end
               MODE_WRITE: begin
                  job_in = JOB_WRITE; shift_in = req_write_data; bit_in = '0;
                  phase_in = PH_SLOT; kind_in = req_write_data[0] ? SK_W1 : SK_W0;
                  tick_in = '0; samp_in = 1'b0; drive_in = 1'b1;
               end
               MODE_READ: begin
                  job_in = JOB_READ; shift_in = '0; bit_in = '0;
                  phase_in = PH_SLOT; kind_in = SK_RD;
                  tick_in = '0; samp_in = 1'b0; drive_in = 1'b1;
               end
               default: begin
                  job_in = JOB_SEARCH; stage_in = ST_RESET;
                  rom_in = '0; lastf_in = '0; forkm_in = '0; done_in = 1'b0;
                  found_in = '0; idpos_in = 7'd1;
                  phase_in = PH_RLOW; tick_in = '0; drive_in = 1'b1;
               end
            endcase
         end
      end else if (phase_ff == PH_IDLE) begin
         drive_in = 1'b0;
      end else begin
         tick_in = tnext;
         case (phase_ff)
            PH_RLOW: begin
               if (tnext >= at_least_one(cfg.reset_low)) begin
                  phase_in = PH_RWAIT; tick_in = '0; drive_in = 1'b0;
               end else begin
                  drive_in = 1'b1;
               end
            end
            PH_RWAIT: begin
               drive_in = 1'b0;
               if (tnext >= at_least_one(cfg.presence_wait)) begin
                  pres_in = !req_line_level; phase_in = PH_RTAIL; tick_in = '0;
               end
            end
            PH_RTAIL: begin
               drive_in = 1'b0;
               if (tnext >= at_least_one(cfg.reset_tail)) begin
                  if (job_ff == JOB_RESET) begin
                     phase_in = PH_IDLE; drive_in = 1'b0;
                     rsp_in.event_res = EV_RESET; rsp_in.presence = pres_ff;
                  end else if (!pres_ff) begin
                     phase_in = PH_IDLE; drive_in = 1'b0;
                     rsp_in.event_res = EV_END; rsp_in.device_count = found_ff;
                  end else begin
                     stage_in = ST_CMD; shift_in = SearchCmd; bit_in = '0;
                     phase_in = PH_SLOT; kind_in = SearchCmd[0] ? SK_W1 : SK_W0;
                     tick_in = '0; samp_in = 1'b0; drive_in = 1'b1;
                  end
               end
            end
            default: begin
               if (kind_ff == SK_RD && tnext == {2'b0, sp_sat}) begin
                  samp_now = req_line_level;
               end
               samp_in = samp_now;
               if (tnext >= {2'b0, sl}) begin
                  // slot finished: restart a slot by default
                  tick_in = '0; drive_in = 1'b1; samp_in = 1'b0; phase_in = PH_SLOT;
                  if (job_ff == JOB_WRITE || (job_ff == JOB_SEARCH && stage_ff == ST_CMD)) begin
                     shift_in = shr;
                     if (bit_ff < 3'd7) begin
                        bit_in = bit_ff + 3'd1;
                        kind_in = shr[0] ? SK_W1 : SK_W0;
                     end else begin
                        bit_in = '0;
                        if (job_ff == JOB_WRITE) begin
                           phase_in = PH_IDLE; drive_in = 1'b0;
                           rsp_in.event_res = EV_WRITE;
                        end else begin
                           stage_in = ST_ID; idpos_in = 7'd1; forkm_in = '0;
                           kind_in = SK_RD;
                        end
                     end
                  end else if (job_ff == JOB_READ) begin
                     shift_in = {samp_now, shift_ff[7:1]};
                     kind_in = SK_RD;
                     if (bit_ff < 3'd7) begin
                        bit_in = bit_ff + 3'd1;
                     end else begin
                        bit_in = '0; phase_in = PH_IDLE; drive_in = 1'b0;
                        rsp_in.event_res = EV_READ;
                        rsp_in.data_byte = {samp_now, shift_ff[7:1]};
                     end
                  end else if (stage_ff == ST_ID) begin
                     first_in = samp_now; stage_in = ST_CMP; kind_in = SK_RD;
                  end else if (stage_ff == ST_CMP) begin
                     cmp = samp_now;
                     if (first_ff && cmp) begin
                        phase_in = PH_IDLE; drive_in = 1'b0;
                        rsp_in.event_res = EV_END; rsp_in.device_count = found_ff;
                     end else begin
                        if (first_ff != cmp) begin
                           dir = first_ff;
                        end else begin
                           if (idpos_ff < lastf_ff) dir = rom_ff[bitpos];
                           else dir = (idpos_ff == lastf_ff);
                           if (!dir) forkm_in = idpos_ff;
                        end
                        rom_in[bitpos] = dir;
                        stage_in = ST_DIR;
                        kind_in = dir ? SK_W1 : SK_W0;
                     end
                  end else begin
                     idpos_in = idnext;
                     if (idnext > 7'd64) begin
                        found_in = fnext; lastf_in = forkm_ff;
                        done_in = (forkm_ff == '0);
                        rsp_in.event_res = EV_FOUND; rsp_in.rom_code = rom_ff;
                        rsp_in.device_count = fnext;
                        rsp_in.last_device = (forkm_ff == '0);
                        if (forkm_ff == '0 || fnext >= maxd) begin
                           phase_in = PH_IDLE; drive_in = 1'b0;
                        end else begin
                           stage_in = ST_RESET; phase_in = PH_RLOW;
                        end
                     end else begin
                        stage_in = ST_ID; kind_in = SK_RD;
                     end
                  end
               end else begin
                  drive_in = (tnext < {2'b0, lo});
               end
            end
         endcase
      end
      rsp_in.line_low = drive_in;
      rsp_in.busy_res = (phase_in != PH_IDLE);
   end

   // output register
   assign vld_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; tick_ff <= '0; bit_ff <= '0; shift_ff <= '0;
         rom_ff <= '0; idpos_ff <= 7'd1; lastf_ff <= '0; forkm_ff <= '0;
         first_ff <= 1'b0; found_ff <= '0; done_ff <= 1'b0; drive_ff <= 1'b0;
         job_ff <= JOB_RESET; stage_ff <= ST_RESET; kind_ff <= SK_W0;
         samp_ff <= 1'b0; pres_ff <= 1'b0; vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (accept) begin
            phase_ff <= phase_in; tick_ff <= tick_in; bit_ff <= bit_in;
            shift_ff <= shift_in; rom_ff <= rom_in; idpos_ff <= idpos_in;
            lastf_ff <= lastf_in; forkm_ff <= forkm_in; first_ff <= first_in;
            found_ff <= found_in; done_ff <= done_in; drive_ff <= drive_in;
            job_ff <= job_in; stage_ff <= stage_in; kind_ff <= kind_in;
            samp_ff <= samp_in; pres_ff <= pres_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp = rsp_ff;

endmodule

[rtl/onewire_master_rom_search.sv]
// onewire_master_rom_search: top level, register bank plus bus sequencer
// depends on owms_pkg, owms_csr, owms_core
//
// usage:
//  req_ channel carries one word per microsecond tick (mode 0, with the
//  sampled line level) or a command (reset, write byte, read byte, search).
//  every accepted word gives exactly one rsp_ word: rsp_line_low is the bus
//  drive for the following tick, rsp_busy_res the command state and
//  rsp_event_res any completion (found rom, search end, rejection...).
//  commands while busy are rejected with no state change.
//  rsp_valid rises in the cycle after acceptance; a word may be taken
//  every cycle, the sequencer state updating in the accepting cycle.
//  a stalled rsp_ready holds the result register; req_ready then drops
//  until the held word is taken, so nothing is lost.
//  reset clears the sequencer to idle, the bus released, and loads the
//  default timing registers. csr_ writes take effect on the next edge and
//  belong only to idle periods.
module onewire_master_rom_search #(
   parameter logic [7:0] MaxDevicesDefault = owms_pkg::DefMaxDevices
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic        req_line_level,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_line_low,
   output logic        rsp_busy_res,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_presence,
   output logic [7:0]  rsp_data_byte,
   output logic [63:0] rsp_rom_code,
   output logic [7:0]  rsp_device_count,
   output logic        rsp_last_device
);
   import owms_pkg::*;

   cfg_type cfg;
   rsp_type rsp;

   owms_csr #(
      .MaxDevicesDefault(MaxDevicesDefault)
   ) u_csr (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   owms_core u_core (
      .clock(clock), .reset(reset), .cfg(cfg),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_line_level(req_line_level), .req_write_data(req_write_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   // unpack result word
   assign rsp_line_low     = rsp.line_low;
   assign rsp_busy_res     = rsp.busy_res;
   assign rsp_event_res    = rsp.event_res;
   assign rsp_presence     = rsp.presence;
   assign rsp_data_byte    = rsp.data_byte;
   assign rsp_rom_code     = rsp.rom_code;
   assign rsp_device_count = rsp.device_count;
   assign rsp_last_device  = rsp.last_device;

endmodule

[rtl/owms_checker.sv]
// owms_checker: port level checks for the rom search master
// depends on owms_pkg; bound to onewire_master_rom_search
module owms_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_presence,
   input logic       rsp_last_device
);
   import owms_pkg::*;

   // accepted word gives a result next cycle
   a_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid) else $error("no result word");

   // stalled result holds its event
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res))
      else $error("result changed under stall");

   // data byte only on read done
   a_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_READ |-> rsp_data_byte == '0)
      else $error("stray data byte");

   // presence and last flag only on their events
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_presence || rsp_event_res == EV_RESET) &&
                    (!rsp_last_device || rsp_event_res == EV_FOUND))
      else $error("stray flag");

endmodule

bind onewire_master_rom_search owms_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_event_res(rsp_event_res),
   .rsp_data_byte(rsp_data_byte), .rsp_presence(rsp_presence),
   .rsp_last_device(rsp_last_device)
);
